@@ sv/lsd_pkg.sv @@
`timescale 1ns / 1ps

package lsd_pkg;

  // Word width of stored keys and listed values
  localparam int unsigned DATA_W = 32;

  // Depth of the command queue between front and back (power of two)
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    OP_PUSH      = 2'd0,
    OP_POP       = 2'd1,
    OP_DUMP_DOWN = 2'd2,
    OP_DUMP_UP   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_POP      = 2'd0,
    ST_LIST     = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  // Classified command handed from the front to the back
  typedef struct packed {
    logic              is_push;
    logic              is_pop;
    logic              bottom_first;
    logic [DATA_W-1:0] key;
  } cmd_t;

endpackage

@@ sv/lsd_front.sv @@
`timescale 1ns / 1ps

module lsd_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 in_opcode_i,
  input  logic signed [lsd_pkg::DATA_W-1:0] in_key_i,
  output logic                       cmd_valid_o,
  input  logic                       cmd_ready_i,
  output lsd_pkg::cmd_t              cmd_o
);

  logic          cmd_valid_q;
  lsd_pkg::cmd_t cmd_q;
  lsd_pkg::cmd_t cmd_d;
  logic          accept;

  // Hold the input only while the registered command cannot move on
  assign in_stall_o = cmd_valid_q && !cmd_ready_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Decode the opcode into command flags
  always_comb begin
    cmd_d              = '0;
    cmd_d.key          = $unsigned(in_key_i);
    unique case (lsd_pkg::opcode_e'(in_opcode_i))
      lsd_pkg::OP_PUSH:      cmd_d.is_push      = 1'b1;
      lsd_pkg::OP_POP:       cmd_d.is_pop       = 1'b1;
      lsd_pkg::OP_DUMP_DOWN: cmd_d.bottom_first = 1'b0;
      lsd_pkg::OP_DUMP_UP:   cmd_d.bottom_first = 1'b1;
      default:               cmd_d.is_pop       = 1'b0;
    endcase
  end

  // Command register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else if (accept) begin
      cmd_valid_q <= 1'b1;
    end else if (cmd_ready_i) begin
      cmd_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_valid_o = cmd_valid_q;
  assign cmd_o       = cmd_q;

endmodule

@@ sv/lsd_queue.sv @@
`timescale 1ns / 1ps

module lsd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  lsd_pkg::cmd_t wr_cmd_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output lsd_pkg::cmd_t rd_cmd_o
);

  lsd_pkg::cmd_t                slots_q [lsd_pkg::QDEPTH];
  logic [lsd_pkg::QAW-1:0]      wr_ptr_q;
  logic [lsd_pkg::QAW-1:0]      rd_ptr_q;
  logic [lsd_pkg::QAW:0]        fill_q;
  logic                         do_wr;
  logic                         do_rd;

  assign wr_ready_o = (fill_q != (lsd_pkg::QAW + 1)'(lsd_pkg::QDEPTH));
  assign rd_valid_o = (fill_q != '0);
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;
  assign rd_cmd_o   = slots_q[rd_ptr_q];

  // Pointers and fill level; pointers wrap on their own
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill_q <= fill_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slots_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

endmodule

@@ sv/lsd_back.sv @@
`timescale 1ns / 1ps

module lsd_back #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cmd_valid_i,
  output logic                               cmd_ready_o,
  input  lsd_pkg::cmd_t                      cmd_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         out_status_o,
  output logic signed [lsd_pkg::DATA_W-1:0]  out_value_o,
  output logic                               out_last_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  // Entry storage, slot 0 at the bottom
  logic [lsd_pkg::DATA_W-1:0] mem [DEPTH];
  logic [lsd_pkg::DATA_W-1:0] rd_data_q;

  logic              state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     rem_q, rem_d;
  logic [AW-1:0]     addr_q, addr_d;
  logic              up_q, up_d;
  lsd_pkg::status_e  stat_q, stat_d;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;

  logic                       out_valid_q;
  lsd_pkg::status_e           out_stat_q, out_stat_d;
  logic [lsd_pkg::DATA_W-1:0] out_val_q, out_val_d;
  logic                       out_last_q, out_last_d;
  logic                       out_load;
  logic                       out_free;

  logic              full;
  logic              empty;
  logic [CW-1:0]     cnt_m1;
  logic [AW-1:0]     top_addr;

  assign out_free = !out_valid_q || !out_stall_i;
  assign full     = (cnt_q == CW'(DEPTH));
  assign empty    = (cnt_q == '0);
  assign cnt_m1   = cnt_q - 1'b1;
  assign top_addr = cnt_m1[AW-1:0];

  // Command execution and dump sequencing
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    addr_d      = addr_q;
    up_d        = up_q;
    stat_d      = stat_q;
    wr_en       = 1'b0;
    wr_addr     = cnt_q[AW-1:0];
    rd_en       = 1'b0;
    rd_addr     = addr_q;
    out_load    = 1'b0;
    out_stat_d  = lsd_pkg::ST_OVERFLOW;
    out_val_d   = '0;
    out_last_d  = 1'b1;
    cmd_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        // an overflow result needs the output register free
        cmd_ready_o = !(cmd_i.is_push && full && !out_free);
        if (cmd_valid_i && cmd_ready_o) begin
          priority if (cmd_i.is_push) begin
            if (full) begin
              out_load = 1'b1;
            end else begin
              wr_en = 1'b1;
              cnt_d = cnt_q + 1'b1;
            end
          end else if (!empty) begin
            rd_en   = 1'b1;
            state_d = S_READ;
            if (cmd_i.is_pop) begin
              rd_addr = top_addr;
              cnt_d   = cnt_m1;
              rem_d   = CW'(1);
              stat_d  = lsd_pkg::ST_POP;
            end else begin
              rd_addr = cmd_i.bottom_first ? '0 : top_addr;
              rem_d   = cnt_q;
              stat_d  = lsd_pkg::ST_LIST;
              up_d    = cmd_i.bottom_first;
            end
            addr_d = rd_addr;
          end else begin
            // pop or dump of an empty stack: nothing to emit
            state_d = S_IDLE;
          end
        end
      end
      S_READ: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_stat_d = stat_q;
          out_val_d  = rd_data_q;
          out_last_d = (rem_q == CW'(1));
          if (rem_q == CW'(1)) begin
            state_d = S_IDLE;
          end else begin
            rem_d   = rem_q - 1'b1;
            rd_en   = 1'b1;
            rd_addr = up_q ? (addr_q + 1'b1) : (addr_q - 1'b1);
            addr_d  = rd_addr;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      rem_q   <= '0;
      addr_q  <= '0;
      up_q    <= 1'b0;
      stat_q  <= lsd_pkg::ST_POP;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
      addr_q  <= addr_d;
      up_q    <= up_d;
      stat_q  <= stat_d;
    end
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd_i.key;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_stat_q <= out_stat_d;
      out_val_q  <= out_val_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_stat_q;
  assign out_value_o  = $signed(out_val_q);
  assign out_last_o   = out_last_q;

endmodule

@@ sv/lifo_stack_with_dump.sv @@
`timescale 1ns / 1ps

// Bounded LIFO stack of signed 32-bit keys with pop and two dump orders.
// A front stage registers and decodes each input word and hands it through
// a two-entry command queue to the back end, which owns the entry memory
// (one write port, one registered read port) and the result register.
// A push is handled without the back end leaving its idle state; a pop
// reads the top entry and then loads the result; a dump reads entry after
// entry, one result per cycle, paced by the single read port and by stalls
// on the result side. While the back end is busy the queue and front still
// take up to three words. Pops and dumps of an empty stack give no result;
// a push onto a full stack gives one overflow result with value zero. The
// entry memory is not cleared at reset and needs no clearing pass.
module lifo_stack_with_dump #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        in_opcode_i,
  input  logic signed [lsd_pkg::DATA_W-1:0] in_key_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        out_status_o,
  output logic signed [lsd_pkg::DATA_W-1:0] out_value_o,
  output logic                              out_last_o
);

  logic          f_valid;
  logic          f_ready;
  lsd_pkg::cmd_t f_cmd;
  logic          b_valid;
  logic          b_ready;
  lsd_pkg::cmd_t b_cmd;

  lsd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_opcode_i (in_opcode_i),
    .in_key_i    (in_key_i),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  lsd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_cmd_i   (f_cmd),
    .rd_valid_o (b_valid),
    .rd_ready_i (b_ready),
    .rd_cmd_o   (b_cmd)
  );

  lsd_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (b_valid),
    .cmd_ready_o  (b_ready),
    .cmd_i        (b_cmd),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_status_o (out_status_o),
    .out_value_o  (out_value_o),
    .out_last_o   (out_last_o)
  );

endmodule

@@ sv/lsd_checker.sv @@
`timescale 1ns / 1ps

module lsd_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [1:0]                        out_status_o,
  input logic signed [lsd_pkg::DATA_W-1:0] out_value_o,
  input logic                              out_last_o
);

  // A stalled result word holds still
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_status_o)
      && $stable(out_value_o) && $stable(out_last_o))
    else $error("result word changed while stalled");

  // Only the three defined status codes appear
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_status_o == lsd_pkg::ST_POP)
      || (out_status_o == lsd_pkg::ST_LIST)
      || (out_status_o == lsd_pkg::ST_OVERFLOW))
    else $error("undefined status code");

  // Overflow reports carry a zero value and close their item
  a_overflow_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_status_o == lsd_pkg::ST_OVERFLOW)
      |-> (out_value_o == '0) && out_last_o)
    else $error("malformed overflow word");

  // A pop gives exactly one word, so it is always the last one
  a_pop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_status_o == lsd_pkg::ST_POP) |-> out_last_o)
    else $error("pop word without last");

  // A word following a non-last listed word continues the same dump
  a_dump_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && (out_status_o == lsd_pkg::ST_LIST) && !out_last_o
      ##1 out_valid_o |-> (out_status_o == lsd_pkg::ST_LIST))
    else $error("dump interrupted by another result");

endmodule

bind lifo_stack_with_dump lsd_checker u_lsd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_status_o (out_status_o),
  .out_value_o  (out_value_o),
  .out_last_o   (out_last_o)
);
